// ----- rtl/gerc_pkg.sv -----
// Shared constants for the gamepad edge, auto-repeat and cursor block.
package gerc_pkg;

    localparam int BTN_W  = 32;
    localparam int AXIS_W = 11;
    localparam int POS_W  = 12;
    localparam int BYTE_W = 8;

    // parameter defaults
    localparam int NUM_BUTTONS_DEF = 32;
    localparam int COUNT_WIDTH_DEF = 8;
    localparam int FULL_SCALE_DEF  = 1000;

    // APB register map, index = paddr[4:2]
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 3;

    localparam logic [REG_IDX_W-1:0] REG_REPEAT_WAIT = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_MOVE_STEP   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_X_MAX       = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_Y_MAX       = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_X_START     = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_Y_START     = 3'd5;

    localparam logic [BYTE_W-1:0] RST_REPEAT_WAIT = 8'd30;
    localparam logic [BYTE_W-1:0] RST_MOVE_STEP   = 8'd5;
    localparam logic [POS_W-1:0]  RST_X_MAX       = 12'd800;
    localparam logic [POS_W-1:0]  RST_Y_MAX       = 12'd600;
    localparam logic [POS_W-1:0]  RST_X_START     = 12'd400;
    localparam logic [POS_W-1:0]  RST_Y_START     = 12'd300;

endpackage

// ----- rtl/gerc_if.sv -----
// Sample and result channel interfaces.
interface gerc_in_if;
    logic                               valid;
    logic                               ready;
    logic                               sample_ok;
    logic [gerc_pkg::BTN_W-1:0]         buttons;
    logic signed [gerc_pkg::AXIS_W-1:0] axis_x;
    logic signed [gerc_pkg::AXIS_W-1:0] axis_y;

    modport source (output valid, sample_ok, buttons, axis_x, axis_y, input ready);
    modport sink   (input valid, sample_ok, buttons, axis_x, axis_y, output ready);
endinterface

interface gerc_out_if;
    logic                        valid;
    logic                        ready;
    logic [gerc_pkg::POS_W-1:0]  cursor_x;
    logic [gerc_pkg::POS_W-1:0]  cursor_y;
    logic [gerc_pkg::BTN_W-1:0]  pressed_mask;
    logic [gerc_pkg::BTN_W-1:0]  trigger_mask;
    logic [gerc_pkg::BTN_W-1:0]  release_mask;
    logic [gerc_pkg::BTN_W-1:0]  repeat_mask;

    modport source (output valid, cursor_x, cursor_y, pressed_mask, trigger_mask,
                    release_mask, repeat_mask, input ready);
    modport sink   (input valid, cursor_x, cursor_y, pressed_mask, trigger_mask,
                    release_mask, repeat_mask, output ready);
endinterface

// ----- rtl/gamepad_edge_repeat_cursor.sv -----
// Top level: button edge detect, auto-repeat counters and clamped cursor.
//
// One sample beat is accepted per clock unless the output stalls; its result beat
// appears in the output register on the next cycle. The input is ready whenever
// the output register is empty or its beat is taken in the same cycle. All
// per-button work (edge detect, hold counter increment and saturate) and the
// cursor add-and-clamp sit in one combinational step between the state
// registers, which double as the result register. A beat with sample_ok low
// leaves all state alone and repeats the last result. Start position writes
// never reach the cursor, which resets to the package defaults; repeat_wait of
// zero makes repeat follow pressed from the first sample.
module gamepad_edge_repeat_cursor #(
    parameter int NUM_BUTTONS = gerc_pkg::NUM_BUTTONS_DEF,
    parameter int COUNT_WIDTH = gerc_pkg::COUNT_WIDTH_DEF,
    parameter int FULL_SCALE  = gerc_pkg::FULL_SCALE_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    gerc_in_if.sink                             i_in,
    gerc_out_if.source                          o_out,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [gerc_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [gerc_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [gerc_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);

    localparam int BTN_W  = gerc_pkg::BTN_W;
    localparam int POS_W  = gerc_pkg::POS_W;
    localparam int BYTE_W = gerc_pkg::BYTE_W;
    localparam int AXIS_W = gerc_pkg::AXIS_W;
    localparam int CMP_W  = (COUNT_WIDTH + 1 > BYTE_W) ? COUNT_WIDTH + 1 : BYTE_W;
    localparam int FS_W   = 17;
    localparam int SUM_W  = POS_W + 2;

    localparam logic [BTN_W-1:0] BTN_MASK =
        BTN_W'((64'd1 << NUM_BUTTONS) - 64'd1);
    localparam logic [CMP_W-1:0] CNT_MAX = CMP_W'({COUNT_WIDTH{1'b1}});
    localparam logic signed [FS_W-1:0] FS_POS = FS_W'(FULL_SCALE);
    localparam logic signed [FS_W-1:0] FS_NEG = -FS_POS;

    // ---------------- configuration registers ----------------
    logic [BYTE_W-1:0] r_repeat_wait, r_move_step;
    logic [POS_W-1:0]  r_x_max, r_y_max, r_x_start, r_y_start;
    logic              cfg_wr;
    logic [gerc_pkg::REG_IDX_W-1:0] cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[gerc_pkg::APB_ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_repeat_wait <= gerc_pkg::RST_REPEAT_WAIT;
            r_move_step   <= gerc_pkg::RST_MOVE_STEP;
            r_x_max       <= gerc_pkg::RST_X_MAX;
            r_y_max       <= gerc_pkg::RST_Y_MAX;
            r_x_start     <= gerc_pkg::RST_X_START;
            r_y_start     <= gerc_pkg::RST_Y_START;
        end else if (cfg_wr) begin
            case (cfg_idx)
                gerc_pkg::REG_REPEAT_WAIT: r_repeat_wait <= pwdata[BYTE_W-1:0];
                gerc_pkg::REG_MOVE_STEP:   r_move_step   <= pwdata[BYTE_W-1:0];
                gerc_pkg::REG_X_MAX:       r_x_max       <= pwdata[POS_W-1:0];
                gerc_pkg::REG_Y_MAX:       r_y_max       <= pwdata[POS_W-1:0];
                gerc_pkg::REG_X_START:     r_x_start     <= pwdata[POS_W-1:0];
                gerc_pkg::REG_Y_START:     r_y_start     <= pwdata[POS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            gerc_pkg::REG_REPEAT_WAIT: prdata = 32'(r_repeat_wait);
            gerc_pkg::REG_MOVE_STEP:   prdata = 32'(r_move_step);
            gerc_pkg::REG_X_MAX:       prdata = 32'(r_x_max);
            gerc_pkg::REG_Y_MAX:       prdata = 32'(r_y_max);
            gerc_pkg::REG_X_START:     prdata = 32'(r_x_start);
            gerc_pkg::REG_Y_START:     prdata = 32'(r_y_start);
            default:                   prdata = '0;
        endcase
    end

    // ---------------- handshake ----------------
    logic r_out_valid;
    logic in_fire, upd;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_fire    = i_in.valid && i_in.ready;
    assign upd        = in_fire && i_in.sample_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // ---------------- cursor ----------------
    function automatic logic [1:0] axis_dir(input logic [AXIS_W-1:0] a);
        logic signed [FS_W-1:0] ax;
        ax = signed'({{(FS_W-AXIS_W){a[AXIS_W-1]}}, a});
        // {up, down}
        return {ax >= FS_POS, ax <= FS_NEG};
    endfunction

    function automatic logic [POS_W-1:0] move_clamp(input logic [POS_W-1:0] pos,
                                                     input logic [1:0] dir,
                                                     input logic [BYTE_W-1:0] step,
                                                     input logic [POS_W-1:0] hi);
        logic [SUM_W-1:0] p;
        logic [SUM_W-1:0] s;
        s = SUM_W'(step);
        if (dir[1]) begin
            p = SUM_W'(pos) + s;
        end else if (dir[0]) begin
            p = SUM_W'(pos) - s;
        end else begin
            p = SUM_W'(pos);
        end
        if (p[SUM_W-1]) begin
            return '0;          // went negative
        end else if (p[SUM_W-2:0] > (SUM_W-1)'(hi)) begin
            return hi;
        end else begin
            return p[POS_W-1:0];
        end
    endfunction

    logic [POS_W-1:0] r_pos_x, r_pos_y, n_pos_x, n_pos_y;

    assign n_pos_x = move_clamp(r_pos_x, axis_dir(i_in.axis_x), r_move_step, r_x_max);
    assign n_pos_y = move_clamp(r_pos_y, axis_dir(i_in.axis_y), r_move_step, r_y_max);

    // ---------------- buttons ----------------
    logic [BTN_W-1:0]       r_prev, r_trig, r_rel, r_rep;
    logic [BTN_W-1:0]       now, n_trig, n_rel, n_rep;
    logic [COUNT_WIDTH-1:0] r_hold [NUM_BUTTONS];
    logic [COUNT_WIDTH-1:0] n_hold [NUM_BUTTONS];
    logic [CMP_W-1:0]       wait_ext;

    assign now      = i_in.buttons & BTN_MASK;
    assign n_trig   = (r_prev ^ now) & now;
    assign n_rel    = (r_prev ^ now) & ~now;
    assign wait_ext = CMP_W'(r_repeat_wait);

    always_comb begin
        logic [CMP_W-1:0] c;
        n_rep = n_trig;
        for (int i = 0; i < NUM_BUTTONS; i++) begin
            c = CMP_W'(r_hold[i]) + CMP_W'(1);
            if (now[i]) begin
                if (c >= wait_ext) begin
                    n_rep[i] = 1'b1;
                end
                if (c > wait_ext) begin
                    c = wait_ext;
                end
                if (c > CNT_MAX) begin
                    c = CNT_MAX;
                end
                n_hold[i] = c[COUNT_WIDTH-1:0];
            end else begin
                n_hold[i] = '0;
            end
        end
        n_rep = n_rep & now;
    end

    // state registers are the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev  <= '0;
            r_trig  <= '0;
            r_rel   <= '0;
            r_rep   <= '0;
            r_pos_x <= gerc_pkg::RST_X_START;
            r_pos_y <= gerc_pkg::RST_Y_START;
            for (int i = 0; i < NUM_BUTTONS; i++) begin
                r_hold[i] <= '0;
            end
        end else if (upd) begin
            r_prev  <= now;
            r_trig  <= n_trig;
            r_rel   <= n_rel;
            r_rep   <= n_rep;
            r_pos_x <= n_pos_x;
            r_pos_y <= n_pos_y;
            for (int i = 0; i < NUM_BUTTONS; i++) begin
                r_hold[i] <= n_hold[i];
            end
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.cursor_x     = r_pos_x;
    assign o_out.cursor_y     = r_pos_y;
    assign o_out.pressed_mask = r_prev;
    assign o_out.trigger_mask = r_trig;
    assign o_out.release_mask = r_rel;
    assign o_out.repeat_mask  = r_rep;

    // ---------------- assertions ----------------
    a_edge_disjoint: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_trig & r_rel) == '0)
        else $error("trigger and release overlap");

    a_hold_on_invalid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && !i_in.sample_ok |=> $stable(r_prev) && $stable(r_pos_x)
                                       && $stable(r_rep))
        else $error("invalid sample changed state");

    a_cursor_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        upd |=> (r_pos_x <= r_x_max) && (r_pos_y <= r_y_max))
        else $error("cursor outside clamp range");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> r_out_valid)
        else $error("accepted sample produced no result");

endmodule

// ----- tb/gamepad_edge_repeat_cursor_tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for the gamepad edge, auto-repeat and cursor block.
module gamepad_edge_repeat_cursor_tb;
    import gerc_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int RAND_PHASES   = 8;
    localparam int PHASE_SAMPLES = 200;
    localparam int CNT_MAX       = (1 << COUNT_WIDTH_DEF) - 1;
    localparam logic [BTN_W-1:0] BTN_MASK = {BTN_W{1'b1}} >> (BTN_W - NUM_BUTTONS_DEF);
    // unmapped register slots, writes must be dropped
    localparam logic [REG_IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_SPARE_B = 3'd7;

    typedef struct packed {
        logic                     ok;
        logic [BTN_W-1:0]         buttons;
        logic signed [AXIS_W-1:0] ax;
        logic signed [AXIS_W-1:0] ay;
    } t_pad_sample;

    typedef struct packed {
        logic [POS_W-1:0] cx;
        logic [POS_W-1:0] cy;
        logic [BTN_W-1:0] pressed;
        logic [BTN_W-1:0] trig;
        logic [BTN_W-1:0] rel;
        logic [BTN_W-1:0] rep;
    } t_pad_report;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    gerc_in_if  smp_if ();
    gerc_out_if rpt_if ();

    gamepad_edge_repeat_cursor i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (smp_if),
        .o_out   (rpt_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // register copies
    logic [BYTE_W-1:0] cfg_wait  = RST_REPEAT_WAIT;
    logic [BYTE_W-1:0] cfg_step  = RST_MOVE_STEP;
    logic [POS_W-1:0]  cfg_x_max = RST_X_MAX;
    logic [POS_W-1:0]  cfg_y_max = RST_Y_MAX;

    // pad state as the block should hold it
    logic [BTN_W-1:0] pad_prev    = '0;
    int               pad_hold[BTN_W];
    logic [POS_W-1:0] pad_x       = RST_X_START;
    logic [POS_W-1:0] pad_y       = RST_Y_START;
    logic [BTN_W-1:0] pad_trig    = '0;
    logic [BTN_W-1:0] pad_rel     = '0;
    logic [BTN_W-1:0] pad_rep     = '0;

    t_pad_sample sample_q[$];
    t_pad_report due_reports[$];
    t_pad_sample cur_smp;

    int in_idle_max  = 0;
    int out_idle_max = 0;
    int gap_left     = 0;
    int stall_left   = 0;
    int cycles       = 0;
    int n_fail       = 0;
    int n_accepted   = 0;
    int n_invalid    = 0;
    int n_checked    = 0;
    int n_held_rep   = 0;
    int n_writes     = 0;
    int n_settings   = 1;

    function automatic int axis_dir(logic signed [AXIS_W-1:0] a);
        if (a >= FULL_SCALE_DEF) return 1;
        if (a <= -FULL_SCALE_DEF) return -1;
        return 0;
    endfunction

    function automatic logic [POS_W-1:0] move_clamped(logic [POS_W-1:0] pos, int dir,
                                                      logic [POS_W-1:0] hi);
        int p;
        p = int'(pos) + dir * int'(cfg_step);
        if (p < 0) p = 0;
        if (p > int'(hi)) p = int'(hi);
        return p[POS_W-1:0];
    endfunction

    // advance the pad state by one sample beat and return the report it yields
    function automatic t_pad_report advance_pad(t_pad_sample s);
        logic [BTN_W-1:0] now;
        logic [BTN_W-1:0] rep;
        int               c;
        if (s.ok) begin
            now   = s.buttons & BTN_MASK;
            pad_x = move_clamped(pad_x, axis_dir(s.ax), cfg_x_max);
            pad_y = move_clamped(pad_y, axis_dir(s.ay), cfg_y_max);
            pad_trig = (pad_prev ^ now) & now;
            pad_rel  = (pad_prev ^ now) & ~now;
            rep = pad_trig;
            for (int i = 0; i < NUM_BUTTONS_DEF; i++) begin
                if (now[i]) begin
                    c = pad_hold[i] + 1;
                    if (c >= int'(cfg_wait)) rep[i] = 1'b1;
                    if (c > int'(cfg_wait)) c = int'(cfg_wait);
                    if (c > CNT_MAX) c = CNT_MAX;
                    pad_hold[i] = c;
                end else begin
                    pad_hold[i] = 0;
                end
            end
            pad_rep  = rep & now;
            pad_prev = now;
        end
        return '{pad_x, pad_y, pad_prev, pad_trig, pad_rel, pad_rep};
    endfunction

    // sample driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            smp_if.valid     <= 1'b0;
            smp_if.sample_ok <= 1'b0;
            smp_if.buttons   <= '0;
            smp_if.axis_x    <= '0;
            smp_if.axis_y    <= '0;
            gap_left = 0;
        end else begin
            if (smp_if.valid && smp_if.ready) begin
                due_reports.push_back(advance_pad(cur_smp));
                n_accepted++;
                if (!cur_smp.ok) n_invalid++;
            end
            if (smp_if.valid && !smp_if.ready) begin
                // beat held until taken
            end else if (gap_left > 0) begin
                gap_left--;
                smp_if.valid <= 1'b0;
            end else if (sample_q.size() > 0) begin
                cur_smp = sample_q.pop_front();
                smp_if.valid     <= 1'b1;
                smp_if.sample_ok <= cur_smp.ok;
                smp_if.buttons   <= cur_smp.buttons;
                smp_if.axis_x    <= cur_smp.ax;
                smp_if.axis_y    <= cur_smp.ay;
                gap_left = $urandom_range(0, in_idle_max);
            end else begin
                smp_if.valid <= 1'b0;
            end
        end
    end

    task automatic check_field(string name, logic [BTN_W-1:0] want, logic [BTN_W-1:0] got);
        if (want !== got) begin
            n_fail++;
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
        end
    endtask

    // report monitor
    always @(posedge i_clk) begin
        t_pad_report want;
        if (!i_rst_n) begin
            rpt_if.ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (rpt_if.valid && rpt_if.ready) begin
                if (due_reports.size() == 0) begin
                    n_fail++;
                    $display("%0t: report beat with nothing expected, got x=%0d y=%0d",
                             $time, rpt_if.cursor_x, rpt_if.cursor_y);
                end else begin
                    want = due_reports.pop_front();
                    check_field("cursor_x", BTN_W'(want.cx), BTN_W'(rpt_if.cursor_x));
                    check_field("cursor_y", BTN_W'(want.cy), BTN_W'(rpt_if.cursor_y));
                    check_field("pressed_mask", want.pressed, rpt_if.pressed_mask);
                    check_field("trigger_mask", want.trig, rpt_if.trigger_mask);
                    check_field("release_mask", want.rel, rpt_if.release_mask);
                    check_field("repeat_mask", want.rep, rpt_if.repeat_mask);
                    n_checked++;
                    if ((want.rep & ~want.trig) != '0) n_held_rep++;
                end
                stall_left = $urandom_range(0, out_idle_max);
            end
            if (stall_left > 0) begin
                stall_left--;
                rpt_if.ready <= 1'b0;
            end else begin
                rpt_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("%0t: timed out with %0d reports pending", $time, due_reports.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic apb_write(logic [REG_IDX_W-1:0] idx, logic [APB_DATA_W-1:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic apb_read(logic [REG_IDX_W-1:0] idx, output logic [APB_DATA_W-1:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        val = prdata;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // write a register, track it and read back the mapped ones
    task automatic set_reg(logic [REG_IDX_W-1:0] idx, logic [APB_DATA_W-1:0] val);
        logic [APB_DATA_W-1:0] kept;
        logic [APB_DATA_W-1:0] got;
        logic                  mapped;
        apb_write(idx, val);
        n_writes++;
        mapped = 1'b1;
        case (idx)
            REG_REPEAT_WAIT: begin cfg_wait = val[BYTE_W-1:0]; kept = cfg_wait; end
            REG_MOVE_STEP:   begin cfg_step = val[BYTE_W-1:0]; kept = cfg_step; end
            REG_X_MAX:       begin cfg_x_max = val[POS_W-1:0]; kept = cfg_x_max; end
            REG_Y_MAX:       begin cfg_y_max = val[POS_W-1:0]; kept = cfg_y_max; end
            // start position is only read back; the cursor never loads it
            REG_X_START, REG_Y_START: kept = val[POS_W-1:0];
            default: mapped = 1'b0;
        endcase
        if (mapped) begin
            apb_read(idx, got);
            if (got !== kept) begin
                n_fail++;
                $display("%0t: register %0d readback, expected %h, got %h",
                         $time, idx, kept, got);
            end
        end
    endtask

    task automatic push_sample(logic ok, logic [BTN_W-1:0] b, logic signed [AXIS_W-1:0] ax,
                               logic signed [AXIS_W-1:0] ay);
        sample_q.push_back('{ok, b, ax, ay});
    endtask

    // block is idle once all beats went in and every report came back
    task automatic wait_idle();
        forever begin
            @(posedge i_clk);
            if (sample_q.size() == 0 && !smp_if.valid && due_reports.size() == 0) break;
        end
        repeat (3) @(posedge i_clk);
    endtask

    function automatic logic signed [AXIS_W-1:0] pick_axis();
        logic signed [AXIS_W-1:0] v;
        if ($urandom_range(0, 9) < 4) begin
            case ($urandom_range(0, 7))
                0: v = 1000;
                1: v = -1000;
                2: v = 999;
                3: v = -999;
                4: v = 1023;
                5: v = -1024;
                6: v = 1001;
                default: v = 0;
            endcase
        end else begin
            v = AXIS_W'($urandom_range(0, 2047));
        end
        return v;
    endfunction

    task automatic random_settings(int phase);
        int r;
        r = $urandom_range(0, 9);
        if (phase == 3) set_reg(REG_REPEAT_WAIT, 255);
        else if (r < 5) set_reg(REG_REPEAT_WAIT, $urandom_range(1, 8));
        else if (r == 5) set_reg(REG_REPEAT_WAIT, 0);
        else if (r == 6) set_reg(REG_REPEAT_WAIT, 255);
        else set_reg(REG_REPEAT_WAIT, $urandom_range(0, 255));
        r = $urandom_range(0, 9);
        if (r == 0) set_reg(REG_MOVE_STEP, 0);
        else if (r == 1) set_reg(REG_MOVE_STEP, 255);
        else if (r < 6) set_reg(REG_MOVE_STEP, $urandom_range(1, 20));
        else set_reg(REG_MOVE_STEP, $urandom_range(0, 255));
        r = $urandom_range(0, 5);
        set_reg(REG_X_MAX, r == 0 ? 0 : r == 1 ? 4095 : $urandom_range(0, 4095));
        r = $urandom_range(0, 5);
        set_reg(REG_Y_MAX, r == 0 ? 0 : r == 1 ? 4095 : $urandom_range(0, 4095));
        if ($urandom_range(0, 3) == 0) begin
            set_reg(REG_X_START, $urandom);
            set_reg(REG_Y_START, $urandom);
        end
        n_settings++;
    endtask

    task automatic random_phase(int phase);
        logic [BTN_W-1:0] held;
        logic [BTN_W-1:0] flip;
        int               stick;
        int               noise;
        int               r;
        // sticky phase keeps buttons held over long runs so hold counters climb high
        stick = (phase == 3) ? 8 : $urandom_range(1, 6);
        noise = (phase == 3) ? 3 : 30;
        held  = $urandom;
        repeat (PHASE_SAMPLES) begin
            r = $urandom_range(0, 99);
            if (r >= noise) begin
                flip = $urandom;
                repeat (stick) flip &= $urandom;
                held ^= flip;
                push_sample(1'b1, held, pick_axis(), pick_axis());
            end else if (r < noise / 3) begin
                push_sample(1'b0, $urandom, AXIS_W'($urandom), AXIS_W'($urandom));
            end else if (r < 2 * noise / 3) begin
                held = $urandom;
                push_sample(1'b1, held, pick_axis(), pick_axis());
            end else begin
                held = $urandom_range(0, 1) ? '1 : '0;
                push_sample(1'b1, held, pick_axis(), pick_axis());
            end
        end
    endtask

    initial begin
        for (int i = 0; i < BTN_W; i++) pad_hold[i] = 0;
        i_rst_n          = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings; invalid beat before any valid one shows reset state
        in_idle_max  = 4;
        out_idle_max = 4;
        push_sample(1'b0, '1, 1023, -1024);
        push_sample(1'b1, '1, 1000, 1000);
        push_sample(1'b1, '1, 1023, -1024);
        push_sample(1'b1, '0, -1000, -1000);
        push_sample(1'b1, 32'hAAAA_AAAA, 999, -999);
        push_sample(1'b1, 32'h5555_5555, 1001, -1001);
        push_sample(1'b0, 32'h1234_5678, 1000, 1000);
        push_sample(1'b1, 32'h8000_0001, 0, 0);
        wait_idle();

        // zero wait, full step, widest range; spare slots must not alias
        set_reg(REG_REPEAT_WAIT, 0);
        set_reg(REG_MOVE_STEP, 255);
        set_reg(REG_X_MAX, 4095);
        set_reg(REG_Y_MAX, 4095);
        set_reg(REG_X_START, 0);
        set_reg(REG_Y_START, 4095);
        set_reg(REG_SPARE_A, '1);
        set_reg(REG_SPARE_B, '1);
        n_settings++;
        push_sample(1'b1, 32'h0000_FFFF, 1000, -1000);
        push_sample(1'b1, 32'h0000_FFFF, -1000, 1000);
        push_sample(1'b1, 32'hFFFF_0000, -1024, -1024);
        push_sample(1'b1, 32'hFFFF_0000, -1000, -1000);
        wait_idle();

        // edges lowered under the cursor pull it in; zero step never moves
        set_reg(REG_REPEAT_WAIT, 255);
        set_reg(REG_MOVE_STEP, 0);
        set_reg(REG_X_MAX, 0);
        set_reg(REG_Y_MAX, 0);
        n_settings++;
        push_sample(1'b1, '1, 0, 0);
        push_sample(1'b1, '1, 1000, 1000);
        push_sample(1'b1, '0, -1000, 1000);
        wait_idle();

        // wait of one: repeat from the first held beat; cursor steps back down to zero
        set_reg(REG_REPEAT_WAIT, 1);
        set_reg(REG_MOVE_STEP, 1);
        set_reg(REG_X_MAX, 4095);
        set_reg(REG_Y_MAX, 4095);
        n_settings++;
        push_sample(1'b1, 32'h0000_0001, 1000, 1000);
        push_sample(1'b1, 32'h0000_0001, 1000, 1000);
        push_sample(1'b1, '0, -1000, -1000);
        push_sample(1'b1, 32'h0000_0003, -1000, -1000);
        push_sample(1'b0, '0, 0, 0);
        wait_idle();

        for (int p = 0; p < RAND_PHASES; p++) begin
            in_idle_max  = (p % 3 == 0) ? 0 : 4;
            out_idle_max = (p % 3 == 1) ? 0 : 4;
            random_settings(p);
            random_phase(p);
            wait_idle();
        end

        repeat (10) @(posedge i_clk);
        if (due_reports.size() != 0) begin
            n_fail += due_reports.size();
            $display("%0t: %0d reports never arrived", $time, due_reports.size());
        end
        $display("Drove %0d samples (%0d not read) over %0d register settings, %0d writes.",
                 n_accepted, n_invalid, n_settings, n_writes);
        $display("Checked %0d reports, %0d with held-button repeat; %0d failures.",
                 n_checked, n_held_rep, n_fail);
        if (n_fail == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
